>>> rtl/cis_pkg.sv
// Shared types and constants for the camera intervalometer sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package cis_pkg;

  // Run phases
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ARMED   = 3'd1,
    PH_FOCUS   = 3'd2,
    PH_SHUTTER = 3'd3,
    PH_HOLD    = 3'd4
  } phase_e;

  // Pin drive codes
  typedef enum logic [1:0] {
    PIN_REL  = 2'd0,
    PIN_HIGH = 2'd1,
    PIN_LOW  = 2'd2
  } pin_e;

  // Control state carried between the state registers and the step logic
  typedef struct packed {
    phase_e phase;
    pin_e   focus;
    pin_e   shutter;
  } ctrl_t;

  // Item function codes
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_COUNT = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FOCUS_DELAY = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHUTTER_HOLD = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INTERVAL = 2'd2;

  // Settle time after both pins go high, in ms
  localparam int unsigned SETTLE_MS = 20;

endpackage

`default_nettype wire

>>> rtl/camera_intervalometer_sequencer.sv
// Camera intervalometer sequencer, top level.
// Depends on cis_pkg, cis_cfg and cis_step.
//
// Usage: each input beat on the in channel (in_valid_i / in_stall_o) is either
// a one-millisecond tick (func_i = 0) or a frame-count write (func_i = 1).
// Each input beat produces exactly one output beat on the out channel
// (out_valid_o / out_stall_i) carrying the pin drive codes, the remaining
// frame count, the frame-done pulse and the current phase.
// The input register loads at the accept edge, the result register when the beat
// advances; a stalled receiver can hold the beat in the input register.
// Throughput: one beat per cycle while the receiver does not stall, set by the
// combinational countdown and phase update between the two registers.
// When the receiver stalls, the result register holds its beat and the
// input register absorbs one more beat; in_stall_o rises only when both
// are full and the output is stalled.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the
// next clock edge; write them only while no beat is in flight.
// Reset clears the control registers (payload registers are not reset):
// configuration zero, phase idle, pins released, frame count zero, both channels empty.
`default_nettype none

module camera_intervalometer_sequencer
  import cis_pkg::*;
#(
  parameter int unsigned TIME_BITS  = 24,
  parameter int unsigned FRAME_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [TIME_BITS-1:0]    cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    func_i,
  input  wire logic [FRAME_BITS-1:0]   frame_count_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic      [1:0]              focus_line_o,
  output logic      [1:0]              shutter_line_o,
  output logic      [FRAME_BITS-1:0]   frames_left_o,
  output logic                         frame_notify_o,
  output logic      [2:0]              phase_o
);

  logic [TIME_BITS-1:0] focus_delay, shutter_hold, interval;

  cis_cfg #(
    .TIME_BITS (TIME_BITS)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .focus_delay_o  (focus_delay),
    .shutter_hold_o (shutter_hold),
    .interval_o     (interval)
  );

  // Input register
  logic                  in_valid_q;
  logic                  func_q;
  logic [FRAME_BITS-1:0] count_q;

  // Block state
  ctrl_t                 ctrl_q, ctrl_d;
  logic [TIME_BITS-1:0]  wait_q, wait_d;
  logic [FRAME_BITS-1:0] frames_q, frames_d;
  logic                  notify_d;

  // Result register
  logic                  out_valid_q;
  ctrl_t                 res_ctrl_q;
  logic [FRAME_BITS-1:0] res_frames_q;
  logic                  res_notify_q;

  logic out_ready, advance, in_take;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  cis_step #(
    .TIME_BITS  (TIME_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_step (
    .func_i         (func_q),
    .frame_count_i  (count_q),
    .focus_delay_i  (focus_delay),
    .shutter_hold_i (shutter_hold),
    .interval_i     (interval),
    .ctrl_i         (ctrl_q),
    .wait_i         (wait_q),
    .frames_i       (frames_q),
    .ctrl_o         (ctrl_d),
    .wait_o         (wait_d),
    .frames_o       (frames_d),
    .notify_o       (notify_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctrl_q      <= '{phase: PH_IDLE, focus: PIN_REL, shutter: PIN_REL};
      wait_q      <= '0;
      frames_q    <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end

      if (advance) begin
        out_valid_q <= 1'b1;
        ctrl_q      <= ctrl_d;
        wait_q      <= wait_d;
        frames_q    <= frames_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q  <= func_i;
      count_q <= frame_count_i;
    end
    if (advance) begin
      res_ctrl_q   <= ctrl_d;
      res_frames_q <= frames_d;
      res_notify_q <= notify_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign focus_line_o   = res_ctrl_q.focus;
  assign shutter_line_o = res_ctrl_q.shutter;
  assign frames_left_o  = res_frames_q;
  assign frame_notify_o = res_notify_q;
  assign phase_o        = res_ctrl_q.phase;

endmodule

`default_nettype wire

>>> rtl/cis_cfg.sv
// Configuration register file: focus delay, shutter hold and interval.
// Depends on cis_pkg for the register indexes.
`default_nettype none

module cis_cfg
  import cis_pkg::*;
#(
  parameter int unsigned TIME_BITS = 24
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [TIME_BITS-1:0]    cfg_wdata_i,
  output logic      [TIME_BITS-1:0]    focus_delay_o,
  output logic      [TIME_BITS-1:0]    shutter_hold_o,
  output logic      [TIME_BITS-1:0]    interval_o
);

  logic [TIME_BITS-1:0] focus_delay_q, shutter_hold_q, interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focus_delay_q  <= '0;
      shutter_hold_q <= '0;
      interval_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FOCUS_DELAY:  focus_delay_q  <= cfg_wdata_i;
        REG_SHUTTER_HOLD: shutter_hold_q <= cfg_wdata_i;
        REG_INTERVAL:     interval_q     <= cfg_wdata_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign focus_delay_o  = focus_delay_q;
  assign shutter_hold_o = shutter_hold_q;
  assign interval_o     = interval_q;

endmodule

`default_nettype wire

>>> rtl/cis_step.sv
// Next-state logic for one item: tick countdown, phase sequencing, frame count.
// Depends on cis_pkg for phase and pin codes and the control struct.
`default_nettype none

module cis_step
  import cis_pkg::*;
#(
  parameter int unsigned TIME_BITS  = 24,
  parameter int unsigned FRAME_BITS = 16
) (
  input  wire logic                  func_i,
  input  wire logic [FRAME_BITS-1:0] frame_count_i,
  input  wire logic [TIME_BITS-1:0]  focus_delay_i,
  input  wire logic [TIME_BITS-1:0]  shutter_hold_i,
  input  wire logic [TIME_BITS-1:0]  interval_i,
  input  wire ctrl_t                 ctrl_i,
  input  wire logic [TIME_BITS-1:0]  wait_i,
  input  wire logic [FRAME_BITS-1:0] frames_i,
  output ctrl_t                      ctrl_o,
  output logic      [TIME_BITS-1:0]  wait_o,
  output logic      [FRAME_BITS-1:0] frames_o,
  output logic                       notify_o
);

  logic [TIME_BITS-1:0]  wait_dec;
  logic [TIME_BITS:0]    active;
  logic [TIME_BITS+1:0]  gap;
  logic [FRAME_BITS-1:0] frames_dec;

  always_comb begin
    wait_dec   = (wait_i != '0) ? wait_i - 1'b1 : '0;
    active     = {1'b0, focus_delay_i} + {1'b0, shutter_hold_i};
    // one extra bit so the sign survives an active time near twice the interval range
    gap        = {2'b0, interval_i} - {1'b0, active};
    frames_dec = frames_i - 1'b1;

    ctrl_o   = ctrl_i;
    wait_o   = wait_i;
    frames_o = frames_i;
    notify_o = 1'b0;

    if (func_i == FUNC_COUNT) begin
      frames_o = frame_count_i;
      if (interval_i != '0 && frame_count_i != '0 && ctrl_i.phase == PH_IDLE) begin
        ctrl_o.phase = PH_ARMED;
      end
    end else begin
      unique case (ctrl_i.phase)
        PH_ARMED: begin
          ctrl_o.focus   = PIN_HIGH;
          ctrl_o.shutter = PIN_HIGH;
          wait_o         = TIME_BITS'(SETTLE_MS);
          ctrl_o.phase   = PH_FOCUS;
        end
        PH_FOCUS, PH_SHUTTER, PH_HOLD: begin
          wait_o = wait_dec;
          if (wait_dec == '0) begin
            if (ctrl_i.phase == PH_FOCUS) begin
              ctrl_o.focus = PIN_LOW;
              wait_o       = focus_delay_i;
              ctrl_o.phase = PH_SHUTTER;
            end else if (ctrl_i.phase == PH_SHUTTER) begin
              ctrl_o.shutter = PIN_LOW;
              wait_o         = shutter_hold_i;
              ctrl_o.phase   = PH_HOLD;
            end else begin
              // end of frame
              notify_o = 1'b1;
              if (frames_i == '0 || frames_dec == '0) begin
                frames_o       = '0;
                ctrl_o.focus   = PIN_REL;
                ctrl_o.shutter = PIN_REL;
                ctrl_o.phase   = PH_IDLE;
              end else begin
                frames_o       = frames_dec;
                ctrl_o.focus   = PIN_HIGH;
                ctrl_o.shutter = PIN_HIGH;
                // interval shorter than the active time: fall back to settle
                wait_o         = gap[TIME_BITS+1] ? TIME_BITS'(SETTLE_MS)
                                                  : gap[TIME_BITS-1:0];
                ctrl_o.phase   = PH_FOCUS;
              end
            end
          end
        end
        default: ;  // idle and unused codes hold
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for camera_intervalometer_sequencer.
// Drives ticks and frame-count writes, predicts pin, count and phase beats
// in-line, and checks every output beat. Depends on cis_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import cis_pkg::*;

  localparam int unsigned TIME_BITS   = 24;
  localparam int unsigned FRAME_BITS  = 16;
  localparam int unsigned RAND_PHASES = 11;
  localparam int unsigned PHASE_BEATS = 150;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef struct {
    logic                  func;
    logic [FRAME_BITS-1:0] count;
  } beat_t;

  typedef struct {
    pin_e                  focus;
    pin_e                  shutter;
    logic [FRAME_BITS-1:0] frames;
    logic                  notify;
    phase_e                phase;
  } lines_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
  logic [TIME_BITS-1:0]    cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    func = FUNC_TICK;
  logic [FRAME_BITS-1:0]   count = '0;
  logic                    out_stall = 1'b0;

  logic                    in_stall_o;
  logic                    out_valid_o;
  logic [1:0]              focus_line_o;
  logic [1:0]              shutter_line_o;
  logic [FRAME_BITS-1:0]   frames_left_o;
  logic                    frame_notify_o;
  logic [2:0]              phase_o;

  beat_t  pending_beats[$];
  lines_t predicted_lines[$];
  logic   in_taken = 1'b0;
  logic   no_idle = 1'b0;
  int     hold_req = 0;
  int     hold_seen = 0;
  int     hold_cnt = 0;
  int     errors = 0;
  int     cycles = 0;

  // Predictor state and its copy of the timing registers
  logic [TIME_BITS-1:0]  m_focus_delay = '0;
  logic [TIME_BITS-1:0]  m_shutter_hold = '0;
  logic [TIME_BITS-1:0]  m_interval = '0;
  phase_e                m_phase = PH_IDLE;
  logic [TIME_BITS-1:0]  m_wait = '0;
  logic [FRAME_BITS-1:0] m_frames = '0;
  pin_e                  m_focus = PIN_REL;
  pin_e                  m_shutter = PIN_REL;

  camera_intervalometer_sequencer #(
    .TIME_BITS (TIME_BITS),
    .FRAME_BITS(FRAME_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .func_i        (func),
    .frame_count_i (count),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .focus_line_o  (focus_line_o),
    .shutter_line_o(shutter_line_o),
    .frames_left_o (frames_left_o),
    .frame_notify_o(frame_notify_o),
    .phase_o       (phase_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic advance_sequencer(input logic f, input logic [FRAME_BITS-1:0] n,
                                   output lines_t r);
    logic          done;
    logic [TIME_BITS:0] active;
    done = 1'b0;
    if (f == FUNC_COUNT) begin
      m_frames = n;
      if (m_interval != 0 && n != 0 && m_phase == PH_IDLE) m_phase = PH_ARMED;
    end else if (m_phase == PH_ARMED) begin
      m_focus   = PIN_HIGH;
      m_shutter = PIN_HIGH;
      m_wait    = TIME_BITS'(SETTLE_MS);
      m_phase   = PH_FOCUS;
    end else if (m_phase != PH_IDLE) begin
      if (m_wait != 0) m_wait = m_wait - 1'b1;
      if (m_wait == 0) begin
        case (m_phase)
          PH_FOCUS: begin
            m_focus = PIN_LOW;
            m_wait  = m_focus_delay;
            m_phase = PH_SHUTTER;
          end
          PH_SHUTTER: begin
            m_shutter = PIN_LOW;
            m_wait    = m_shutter_hold;
            m_phase   = PH_HOLD;
          end
          default: begin
            done = 1'b1;
            if (m_frames != 0) m_frames = m_frames - 1'b1;
            if (m_frames == 0) begin
              m_focus   = PIN_REL;
              m_shutter = PIN_REL;
              m_phase   = PH_IDLE;
            end else begin
              m_focus   = PIN_HIGH;
              m_shutter = PIN_HIGH;
              active    = {1'b0, m_focus_delay} + {1'b0, m_shutter_hold};
              // Fall back to the settle time when the active part overruns
              if ({1'b0, m_interval} >= active) m_wait = m_interval - active[TIME_BITS-1:0];
              else m_wait = TIME_BITS'(SETTLE_MS);
              m_phase = PH_FOCUS;
            end
          end
        endcase
      end
    end
    r.focus   = m_focus;
    r.shutter = m_shutter;
    r.frames  = m_frames;
    r.notify  = done;
    r.phase   = m_phase;
  endtask

  // Input driver: hold the beat until taken, then advance the queue
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_valid) void'(pending_beats.pop_front());
      if (pending_beats.size() != 0 && (no_idle || $urandom_range(0, 99) >= 28)) begin
        in_valid <= 1'b1;
        func     <= pending_beats[0].func;
        count    <= pending_beats[0].count;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt  <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 28);
    end
  end

  always @(posedge clk_i) begin
    lines_t want;
    lines_t exp_l;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall_o;
      if (in_valid && !in_stall_o) begin
        advance_sequencer(func, count, want);
        predicted_lines.push_back(want);
      end
      if (out_valid_o && !out_stall) begin
        if (predicted_lines.size() == 0) begin
          $error("output beat with nothing expected");
          errors++;
        end else begin
          exp_l = predicted_lines.pop_front();
          if (focus_line_o != exp_l.focus) begin
            $error("focus_line expected %0d got %0d", exp_l.focus, focus_line_o);
            errors++;
          end
          if (shutter_line_o != exp_l.shutter) begin
            $error("shutter_line expected %0d got %0d", exp_l.shutter, shutter_line_o);
            errors++;
          end
          if (frames_left_o != exp_l.frames) begin
            $error("frames_left expected %0d got %0d", exp_l.frames, frames_left_o);
            errors++;
          end
          if (frame_notify_o != exp_l.notify) begin
            $error("frame_notify expected %0d got %0d", exp_l.notify, frame_notify_o);
            errors++;
          end
          if (phase_o != exp_l.phase) begin
            $error("phase expected %0d got %0d", exp_l.phase, phase_o);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_beat(input logic f, input logic [FRAME_BITS-1:0] n);
    beat_t b;
    b.func  = f;
    b.count = n;
    pending_beats.push_back(b);
  endtask

  task automatic queue_ticks(input int n);
    for (int i = 0; i < n; i++) queue_beat(FUNC_TICK, FRAME_BITS'($urandom));
  endtask

  task automatic queue_random_beat();
    int pick;
    pick = $urandom_range(0, 999);
    if (pick < 18) queue_beat(FUNC_COUNT, FRAME_BITS'($urandom_range(1, 3)));
    else if (pick < 23) queue_beat(FUNC_COUNT, '0);
    else if (pick < 26) queue_beat(FUNC_COUNT, FRAME_BITS'($urandom));
    else queue_beat(FUNC_TICK, FRAME_BITS'($urandom));
  endtask

  // Wait until every beat is taken and answered, then let the pipe settle
  task automatic drain_results();
    while (pending_beats.size() != 0 || predicted_lines.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [TIME_BITS-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_FOCUS_DELAY:  m_focus_delay  = val;
      REG_SHUTTER_HOLD: m_shutter_hold = val;
      REG_INTERVAL:     m_interval     = val;
      default: ;
    endcase
  endtask

  initial begin
    logic [2:0] mask;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle tick, then a count write that cannot arm with a zero interval
    queue_beat(FUNC_TICK, '1);
    queue_beat(FUNC_COUNT, 16'd5);
    drain_results();

    // All-ones timing; arm with the largest count and start the settle
    write_reg(REG_FOCUS_DELAY, TIME_MAX);
    write_reg(REG_SHUTTER_HOLD, TIME_MAX);
    write_reg(REG_INTERVAL, TIME_MAX);
    queue_beat(FUNC_COUNT, '1);
    queue_ticks(1);
    drain_results();

    // Shrink the delays mid-run, rewrite the count to one, and finish the frame
    write_reg(REG_FOCUS_DELAY, '0);
    write_reg(REG_SHUTTER_HOLD, '0);
    queue_beat(FUNC_COUNT, 16'd1);
    queue_ticks(SETTLE_MS + 2);
    drain_results();

    for (int p = 0; p < RAND_PHASES; p++) begin
      mask = (p == 0) ? 3'b111 : 3'($urandom_range(1, 7));
      if (mask[0]) write_reg(REG_FOCUS_DELAY, TIME_BITS'($urandom_range(0, 8)));
      if (mask[1]) write_reg(REG_SHUTTER_HOLD, TIME_BITS'($urandom_range(0, 8)));
      if (mask[2]) begin
        if (p == 7 || $urandom_range(0, 7) == 0) write_reg(REG_INTERVAL, '0);
        else write_reg(REG_INTERVAL, TIME_BITS'($urandom_range(1, 40)));
      end
      no_idle = (p == 3);
      for (int i = 0; i < PHASE_BEATS; i++) queue_random_beat();
      if (p == 6) hold_req = hold_req + 1;
      drain_results();
    end

    no_idle = 1'b0;
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
rtl/cis_pkg.sv
rtl/cis_cfg.sv
rtl/cis_step.sv
rtl/camera_intervalometer_sequencer.sv
sim/tb.sv
